FILE: src/qvr_pkg.sv
package qvr_pkg;

  // Register stages from the accepted word to the result registers.
  localparam int unsigned QVR_STAGES = 6;

  typedef logic [QVR_STAGES-1:0] qvr_vld_t;

endpackage

FILE: src/quaternion_vector_rotate.sv
// Rotates a signed integer vector by a quaternion, v' = q v q*, evaluated exactly
// in matrix form and rounded to the nearest integer with ties toward plus infinity.
// Input channel: a word of in_vec_x/y/z and in_quat_w/x/y/z is taken at a rising
// edge where start is high and busy is low. Quaternion parts are signed fixed point
// with QUAT_FRAC_BITS fraction bits, so one is 1 << QUAT_FRAC_BITS.
// Result channel: out_valid is high for one cycle with out_rot_x/y/z and
// out_saturated; the word is taken at the edge that ends that cycle.
// Throughput is one word per cycle; busy stays low, since each of the six stages
// (component products, matrix entries, split partial products, term merge, row sum,
// round and clip) moves on every cycle.
// A component outside the signed VEC_WIDTH range is clipped to the nearer bound
// and out_saturated is set for that word.
// A synchronous reset clears the valid bits of all stages, so words in flight are
// dropped and no strobe appears until new words arrive. The receiver cannot hold
// results off, so nothing in the pipeline ever stalls.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int unsigned VEC_WIDTH      = 16,
  parameter int unsigned QUAT_WIDTH     = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_z,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_z,
  output logic                         out_valid,
  output logic signed [VEC_WIDTH-1:0]  out_rot_x,
  output logic signed [VEC_WIDTH-1:0]  out_rot_y,
  output logic signed [VEC_WIDTH-1:0]  out_rot_z,
  output logic                         out_saturated
);

  localparam int unsigned PW   = 2 * QUAT_WIDTH;
  localparam int unsigned MW   = 2 * QUAT_WIDTH + 2;
  localparam int unsigned SPL  = QUAT_WIDTH + 1;
  localparam int unsigned HW   = MW - SPL;
  localparam int unsigned PLW  = SPL + 1 + VEC_WIDTH;
  localparam int unsigned PHW  = HW + VEC_WIDTH;
  localparam int unsigned AW   = MW + VEC_WIDTH + 4;
  localparam int unsigned SH   = 2 * QUAT_FRAC_BITS;
  localparam int unsigned EW   = ((AW > SH + 1) ? AW : SH + 1) + 1;
  localparam logic signed [EW-1:0] HALF = EW'(1) << (SH - 1);
  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  qvr_vld_t vld_r, vld_nxt;

  logic signed [PW-1:0]        pp_r  [10];
  logic signed [PW-1:0]        pp_nxt[10];
  logic signed [VEC_WIDTH-1:0] v1_r  [3];
  logic signed [VEC_WIDTH-1:0] v2_r  [3];
  logic signed [MW-1:0]        m_r   [3][3];
  logic signed [MW-1:0]        m_nxt [3][3];
  logic signed [PHW-1:0]       ph_r  [3][3];
  logic signed [PHW-1:0]       ph_nxt[3][3];
  logic signed [PLW-1:0]       pl_r  [3][3];
  logic signed [PLW-1:0]       pl_nxt[3][3];
  logic signed [AW-1:0]        t_r   [3][3];
  logic signed [AW-1:0]        t_nxt [3][3];
  logic signed [AW-1:0]        s_r   [3];
  logic signed [AW-1:0]        s_nxt [3];
  logic signed [VEC_WIDTH-1:0] rot_r [3];
  logic signed [VEC_WIDTH-1:0] rot_nxt[3];
  logic                        sat_r, sat_nxt;

  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;

  assign busy = 1'b0;
  assign qw   = in_quat_w;
  assign qx   = in_quat_x;
  assign qy   = in_quat_y;
  assign qz   = in_quat_z;

  assign vld_nxt = {vld_r[QVR_STAGES-2:0], start};

  always_comb begin
    pp_nxt[0] = PW'(qw) * PW'(qw);
    pp_nxt[1] = PW'(qx) * PW'(qx);
    pp_nxt[2] = PW'(qy) * PW'(qy);
    pp_nxt[3] = PW'(qz) * PW'(qz);
    pp_nxt[4] = PW'(qx) * PW'(qy);
    pp_nxt[5] = PW'(qw) * PW'(qz);
    pp_nxt[6] = PW'(qx) * PW'(qz);
    pp_nxt[7] = PW'(qw) * PW'(qy);
    pp_nxt[8] = PW'(qy) * PW'(qz);
    pp_nxt[9] = PW'(qw) * PW'(qx);
  end

  always_comb begin
    m_nxt[0][0] = MW'(pp_r[0]) + MW'(pp_r[1]) - MW'(pp_r[2]) - MW'(pp_r[3]);
    m_nxt[0][1] = (MW'(pp_r[4]) - MW'(pp_r[5])) <<< 1;
    m_nxt[0][2] = (MW'(pp_r[6]) + MW'(pp_r[7])) <<< 1;
    m_nxt[1][0] = (MW'(pp_r[4]) + MW'(pp_r[5])) <<< 1;
    m_nxt[1][1] = MW'(pp_r[0]) - MW'(pp_r[1]) + MW'(pp_r[2]) - MW'(pp_r[3]);
    m_nxt[1][2] = (MW'(pp_r[8]) - MW'(pp_r[9])) <<< 1;
    m_nxt[2][0] = (MW'(pp_r[6]) - MW'(pp_r[7])) <<< 1;
    m_nxt[2][1] = (MW'(pp_r[8]) + MW'(pp_r[9])) <<< 1;
    m_nxt[2][2] = MW'(pp_r[0]) - MW'(pp_r[1]) - MW'(pp_r[2]) + MW'(pp_r[3]);
  end

  // Each matrix entry is split into a signed upper part and an unsigned lower
  // part so that no single multiplier grows past the width of one operand pair.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        ph_nxt[j][k] = PHW'($signed(m_r[j][k][MW-1:SPL])) * PHW'(v2_r[k]);
        pl_nxt[j][k] = PLW'($signed({1'b0, m_r[j][k][SPL-1:0]})) * PLW'(v2_r[k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        t_nxt[j][k] = (AW'(ph_r[j][k]) <<< SPL) + AW'(pl_r[j][k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s_nxt[j] = t_r[j][0] + t_r[j][1] + t_r[j][2];
    end
  end

  always_comb begin
    logic signed [EW-1:0]       rnd;
    logic [EW-VEC_WIDTH:0]      top;
    sat_nxt = 1'b0;
    for (int j = 0; j < 3; j++) begin
      rnd = (EW'(s_r[j]) + HALF) >>> SH;
      top = rnd[EW-1:VEC_WIDTH-1];
      if ((&top) || !(|top)) begin
        rot_nxt[j] = rnd[VEC_WIDTH-1:0];
      end else begin
        sat_nxt    = 1'b1;
        rot_nxt[j] = rnd[EW-1] ? VMIN : VMAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= pp_nxt;
    v1_r[0] <= in_vec_x;
    v1_r[1] <= in_vec_y;
    v1_r[2] <= in_vec_z;
    m_r     <= m_nxt;
    v2_r    <= v1_r;
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
    t_r     <= t_nxt;
    s_r     <= s_nxt;
    rot_r   <= rot_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_valid     = vld_r[QVR_STAGES-1];
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_saturated = sat_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##6 out_valid)
    else $error("Accepted word did not produce a result after six cycles.");

  a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_quat_w == '0 && in_quat_x == '0 && in_quat_y == '0 && in_quat_z == '0
    |-> ##6 (out_rot_x == '0 && out_rot_y == '0 && out_rot_z == '0 && !out_saturated))
    else $error("Zero quaternion gave a nonzero or saturated result.");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_rot_x == VMAX || out_rot_x == VMIN || out_rot_y == VMAX || out_rot_y == VMIN ||
       out_rot_z == VMAX || out_rot_z == VMIN))
    else $error("Saturation flagged but no component sits at a range bound.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[0], 5))
    else $error("Result strobe without a matching accepted word.");
`endif

endmodule

FILE: verif/tb_quaternion_vector_rotate.sv
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int VW = 16;
  localparam int QW = 16;
  localparam int QF = 14;
  localparam longint ROT_HALF = 64'sd1 <<< (2 * QF - 1);
  localparam longint ROT_MAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint ROT_MIN = -(64'sd1 <<< (VW - 1));

  typedef struct {
    logic signed [VW-1:0] vx, vy, vz;
    logic signed [QW-1:0] qw, qx, qy, qz;
  } rot_word_t;

  typedef struct {
    logic signed [VW-1:0] x, y, z;
    logic                 sat;
  } rot_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [VW-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [QW-1:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic                 out_valid;
  logic signed [VW-1:0] out_rot_x, out_rot_y, out_rot_z;
  logic                 out_saturated;

  rot_result_t rot_pending[$];
  int          mismatch_count = 0;

  quaternion_vector_rotate #(
    .VEC_WIDTH     (VW),
    .QUAT_WIDTH    (QW),
    .QUAT_FRAC_BITS(QF)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .in_quat_w    (in_quat_w),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .out_valid    (out_valid),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_quaternion_vector_rotate: done, errors");
    $finish;
  end

  // Exact matrix form of q v q*, rounded half up and clipped to the vector range.
  function automatic rot_result_t rotate_vector(rot_word_t r);
    longint w, x, y, z, vx, vy, vz;
    longint row[3];
    longint rnd;
    logic signed [VW-1:0] comp[3];
    rot_result_t res;
    w = r.qw;
    x = r.qx;
    y = r.qy;
    z = r.qz;
    vx = r.vx;
    vy = r.vy;
    vz = r.vz;
    row[0] = (w*w + x*x - y*y - z*z) * vx + 2 * (x*y - w*z) * vy + 2 * (x*z + w*y) * vz;
    row[1] = 2 * (x*y + w*z) * vx + (w*w - x*x + y*y - z*z) * vy + 2 * (y*z - w*x) * vz;
    row[2] = 2 * (x*z - w*y) * vx + 2 * (y*z + w*x) * vy + (w*w - x*x - y*y + z*z) * vz;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd = (row[i] + ROT_HALF) >>> (2 * QF);
      if (rnd > ROT_MAX) begin
        comp[i] = ROT_MAX[VW-1:0];
        res.sat = 1'b1;
      end else if (rnd < ROT_MIN) begin
        comp[i] = ROT_MIN[VW-1:0];
        res.sat = 1'b1;
      end else begin
        comp[i] = rnd[VW-1:0];
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  function automatic rot_word_t make_word(longint vx, longint vy, longint vz,
                                          longint qw, longint qx, longint qy, longint qz);
    rot_word_t r;
    r.vx = vx[VW-1:0];
    r.vy = vy[VW-1:0];
    r.vz = vz[VW-1:0];
    r.qw = qw[QW-1:0];
    r.qx = qx[QW-1:0];
    r.qy = qy[QW-1:0];
    r.qz = qz[QW-1:0];
    return r;
  endfunction

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd1;
      5: return 16'sd16384;
      6: return -16'sd16384;
      default: return 16'sd11585;
    endcase
  endfunction

  function automatic rot_word_t random_word();
    rot_word_t r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r.vx = VW'($urandom());
    r.vy = VW'($urandom());
    r.vz = VW'($urandom());
    r.qw = QW'($urandom());
    r.qx = QW'($urandom());
    r.qy = QW'($urandom());
    r.qz = QW'($urandom());
    if (mode >= 4 && mode <= 6) begin
      // Quaternions of norm at most one, so most results stay in range.
      r.qw = QW'($signed($urandom_range(0, 16384)) - 16'sd8192);
      r.qx = QW'($signed($urandom_range(0, 16384)) - 16'sd8192);
      r.qy = QW'($signed($urandom_range(0, 16384)) - 16'sd8192);
      r.qz = QW'($signed($urandom_range(0, 16384)) - 16'sd8192);
    end else if (mode == 7) begin
      r.vx = corner_value();
      r.vy = corner_value();
      r.vz = corner_value();
      r.qw = corner_value();
      r.qx = corner_value();
      r.qy = corner_value();
      r.qz = corner_value();
    end else if (mode >= 8) begin
      r.vx = VW'($signed($urandom_range(0, 128)) - 16'sd64);
      r.vy = VW'($signed($urandom_range(0, 128)) - 16'sd64);
      r.vz = VW'($signed($urandom_range(0, 128)) - 16'sd64);
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rot_result_t want;
    if (rst_n && out_valid) begin
      if (rot_pending.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected, actual %0d %0d %0d sat %0b",
                 $time, out_rot_x, out_rot_y, out_rot_z, out_saturated);
      end else begin
        want = rot_pending.pop_front();
        check_field("rot_x", want.x, out_rot_x);
        check_field("rot_y", want.y, out_rot_y);
        check_field("rot_z", want.z, out_rot_z);
        check_field("saturated", want.sat, out_saturated);
      end
    end
  end

  task automatic send_word(rot_word_t r);
    @(negedge clk);
    in_vec_x = r.vx;
    in_vec_y = r.vy;
    in_vec_z = r.vz;
    in_quat_w = r.qw;
    in_quat_x = r.qx;
    in_quat_y = r.qy;
    in_quat_z = r.qz;
    start = 1'b1;
    do @(posedge clk); while (busy);
    rot_pending.push_back(rotate_vector(r));
  endtask

  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic wait_for_drain();
    pause_sender(1);
    while (rot_pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    send_word(make_word(32767, -32768, 1, 16384, 0, 0, 0));
    send_word(make_word(-32768, 32767, -1, -16384, 0, 0, 0));
    send_word(make_word(32767, -32768, 32767, 0, 0, 0, 0));
    send_word(make_word(1000, 0, 0, 11585, 0, 0, 11585));
    send_word(make_word(0, 1000, -500, 11585, 11585, 0, 0));
    send_word(make_word(-700, 300, 2000, 11585, 0, -11585, 0));
    send_word(make_word(100, 200, 300, 0, 16384, 0, 0));
    send_word(make_word(2, -2, 6, 8192, 0, 0, 0));
    send_word(make_word(-6, 10, -10, 8192, 0, 0, 0));
    send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_word(make_word(1, 1, 1, -32768, 0, 0, 0));
    send_word(make_word(-32768, 32767, 0, 0, 32767, 0, 0));
    send_word(make_word(32767, 0, -32768, 0, 0, -32768, 0));
    send_word(make_word(0, -32768, 32767, 0, 0, 0, -32768));
    send_word(make_word(-1, -1, -1, 9459, 9459, 9459, 9459));
    send_word(make_word(12345, -23456, 31000, 8192, -8192, 8192, -8192));
    send_word(make_word(32767, 32767, 32767, 16384, 16384, 0, 0));
    pause_sender(3);
  endtask

  task automatic test_back_to_back();
    repeat (200) send_word(random_word());
    wait_for_drain();
  endtask

  task automatic test_random_bursts();
    int burst_left;
    burst_left = $urandom_range(1, 40);
    for (int n = 1; n <= 1530; n++) begin
      send_word(random_word());
      burst_left--;
      if (n % 500 == 0) begin
        wait_for_drain();
      end else if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_corner_cases();
    test_back_to_back();
    test_random_bursts();
    wait_for_drain();
    repeat (QVR_STAGES + 4) @(posedge clk);
    if (rot_pending.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected result words never arrived", $time, rot_pending.size());
    end
    if (mismatch_count == 0) begin
      $display("tb_quaternion_vector_rotate: done, clean");
    end else begin
      $display("tb_quaternion_vector_rotate: done, errors");
    end
    $finish;
  end

endmodule
